FILE: src/md5_pkg.sv
// md5_pkg: shared constants, types and round tables for the md5 digest block
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package md5_pkg;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 32;
	localparam int IDX_W   = 2;
	localparam int COUNT_W = 64;

	localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
	localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
	localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
	localparam logic [WORD_W-1:0] IV_D = 32'h10325476;
	localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FOLD  = 4'b0100,
		ST_EMIT  = 4'b1000
	} md5_state_t;

	// what block follows the one being compressed during the finish
	typedef enum logic [1:0] {
		NXT_NONE     = 2'd0,
		NXT_MARK_LEN = 2'd1,
		NXT_LEN      = 2'd2
	} md5_next_t;

	function automatic logic [WORD_W-1:0] round_k(input logic [5:0] i);
		logic [WORD_W-1:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] round_shift(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
			4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
			4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
			4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word index for round i, all arithmetic mod 16
	function automatic logic [3:0] word_sel(input logic [5:0] i);
		logic [3:0] r;
		logic [3:0] g;
		r = i[3:0];
		case (i[5:4])
			2'd0:    g = r;
			2'd1:    g = 4'((r << 2) + r + 4'd1);
			2'd2:    g = 4'((r << 1) + r + 4'd5);
			2'd3:    g = 4'((r << 3) - r);
			default: g = r;
		endcase
		return g;
	endfunction

endpackage

FILE: src/md5_in_if.sv
// md5_in_if: message byte channel, valid/ready with byte and flags
// depends on md5_pkg for field widths
`timescale 1ns / 1ps

interface md5_in_if;
	logic                       valid;
	logic                       ready;
	logic [md5_pkg::BYTE_W-1:0] data_byte;
	logic                       has_byte;
	logic                       last_byte;

	modport source (output valid, data_byte, has_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

FILE: src/md5_out_if.sv
// md5_out_if: digest word channel, valid/ready with word, index and last flag
// depends on md5_pkg for field widths
`timescale 1ns / 1ps

interface md5_out_if;
	logic                       valid;
	logic                       ready;
	logic [md5_pkg::WORD_W-1:0] digest_word;
	logic [md5_pkg::IDX_W-1:0]  word_index;
	logic                       last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: src/md5_message_digest.sv
// md5_message_digest: byte-stream md5 engine with a one-round-per-cycle compressor
// depends on md5_pkg, md5_in_if and md5_out_if
`timescale 1ns / 1ps

//  channel | dir | transfer carries                      | when
//  --------+-----+---------------------------------------+-------------------------
//  msg     | in  | data_byte, has_byte, last_byte        | valid & ready
//  digest  | out | digest_word, word_index, last_word    | valid & ready
//
//  an item that does not complete a block or end the message leaves the engine idle
//  an item that fills the block starts 64 rounds through the single
//  round unit plus one fold into the chaining words and the return to idle
//  a last item runs one or two blocks, padding and length included, then four
//  digest transfers at most one per cycle; the output register lets the next
//  message start while the final word still waits to be taken
//  arst_n clears control, the chaining words to the initial vector and the
//  bit count; the block store needs no clearing

module md5_message_digest (
	input  logic       clk,
	input  logic       arst_n,
	md5_in_if.sink     msg,
	md5_out_if.source  digest
);

	localparam int LEN_W = 7; // valid bytes in the block under compression, 0..64

	md5_pkg::md5_state_t state_q;
	md5_pkg::md5_next_t  nxt_q;
	logic                fin_q;

	logic [5:0]                        fill_q;
	logic [md5_pkg::COUNT_W-1:0]       bit_cnt_q;
	logic [3:0][md5_pkg::WORD_W-1:0]   chain_q;
	logic [md5_pkg::WORD_W-1:0]        blk_q [16];

	// how the current block is read: stored bytes, pad mark, length field
	logic [LEN_W-1:0] blk_valid_q;
	logic             blk_mark_q;
	logic             blk_len_q;

	logic [5:0]                  rnd_q;
	logic [md5_pkg::WORD_W-1:0]  a_q, b_q, c_q, d_q;

	logic [md5_pkg::IDX_W-1:0]   emit_idx_q;
	logic                        out_vld_q;
	logic [md5_pkg::WORD_W-1:0]  out_word_q;
	logic [md5_pkg::IDX_W-1:0]   out_idx_q;
	logic                        out_last_q;

	// input side
	logic       take;
	logic [5:0] fill_inc;
	logic [5:0] fill_end;
	logic       blk_full;

	assign msg.ready = (state_q == md5_pkg::ST_IDLE);
	assign take      = msg.valid && msg.ready;
	assign fill_inc  = fill_q + 6'd1;
	assign fill_end  = msg.has_byte ? fill_inc : fill_q;
	assign blk_full  = msg.has_byte && (fill_q == 6'd63);

	// message word for this round, with padding and length laid over the store
	logic [3:0]                 g_sel;
	logic [md5_pkg::WORD_W-1:0] w_raw;
	logic [md5_pkg::WORD_W-1:0] w_cur;

	assign g_sel = md5_pkg::word_sel(rnd_q);
	assign w_raw = blk_q[g_sel];

	always_comb begin
		logic [5:0] pos;
		w_cur = '0;
		for (int k = 0; k < 4; k++) begin
			pos = {g_sel, 2'(k)};
			if ({1'b0, pos} < blk_valid_q) begin
				w_cur[8*k +: 8] = w_raw[8*k +: 8];
			end else if (blk_mark_q && ({1'b0, pos} == blk_valid_q)) begin
				w_cur[8*k +: 8] = md5_pkg::PAD_MARK;
			end else if (blk_len_q && (pos[5:3] == 3'b111)) begin
				w_cur[8*k +: 8] = bit_cnt_q[8*pos[2:0] +: 8];
			end
		end
	end

	// the shared round unit
	logic [md5_pkg::WORD_W-1:0] f_val;
	logic [md5_pkg::WORD_W-1:0] t_sum;
	logic [4:0]                 sh;
	logic [63:0]                rot_dbl;
	logic [md5_pkg::WORD_W-1:0] b_new;

	always_comb begin
		case (rnd_q[5:4])
			2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f_val = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f_val = b_q ^ c_q ^ d_q;
			2'd3:    f_val = c_q ^ (b_q | ~d_q);
			default: f_val = '0;
		endcase
	end

	assign t_sum   = a_q + f_val + w_cur + md5_pkg::round_k(rnd_q);
	assign sh      = md5_pkg::round_shift(rnd_q);
	assign rot_dbl = {t_sum, t_sum} << sh;
	assign b_new   = b_q + rot_dbl[63:32];

	// chaining words after the fold
	logic [3:0][md5_pkg::WORD_W-1:0] fold_sum;

	assign fold_sum[0] = chain_q[0] + a_q;
	assign fold_sum[1] = chain_q[1] + b_q;
	assign fold_sum[2] = chain_q[2] + c_q;
	assign fold_sum[3] = chain_q[3] + d_q;

	// block store: byte lanes of sixteen words, no reset
	always_ff @(posedge clk) begin
		if (take && msg.has_byte) begin
			blk_q[fill_q[5:2]][8*fill_q[1:0] +: 8] <= msg.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == md5_pkg::ST_EMIT && (!out_vld_q || digest.ready)) begin
			out_word_q <= chain_q[emit_idx_q];
			out_idx_q  <= emit_idx_q;
			out_last_q <= (emit_idx_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= md5_pkg::ST_IDLE;
			nxt_q       <= md5_pkg::NXT_NONE;
			fin_q       <= 1'b0;
			fill_q      <= '0;
			bit_cnt_q   <= '0;
			chain_q     <= {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
			blk_valid_q <= '0;
			blk_mark_q  <= 1'b0;
			blk_len_q   <= 1'b0;
			rnd_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			d_q         <= '0;
			emit_idx_q  <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			// output register loads in emit when empty or taken, holds until taken otherwise
			out_vld_q <= (state_q == md5_pkg::ST_EMIT) || (out_vld_q && !digest.ready);
			case (state_q)
				md5_pkg::ST_IDLE: begin
					if (take) begin
						if (msg.has_byte) begin
							bit_cnt_q <= bit_cnt_q + md5_pkg::COUNT_W'(8);
						end
						if (msg.has_byte || msg.last_byte) begin
							// an end of message starts the next one from byte 0
							fill_q <= msg.last_byte ? 6'd0 : fill_inc;
						end
						if (blk_full) begin
							// full block first; an end of message pads a fresh block
							blk_valid_q <= LEN_W'(64);
							blk_mark_q  <= 1'b0;
							blk_len_q   <= 1'b0;
							nxt_q       <= msg.last_byte ? md5_pkg::NXT_MARK_LEN
							                             : md5_pkg::NXT_NONE;
							fin_q       <= msg.last_byte;
						end else if (msg.last_byte) begin
							// mark after the data; length fits only below byte 56
							blk_valid_q <= {1'b0, fill_end};
							blk_mark_q  <= 1'b1;
							blk_len_q   <= (fill_end < 6'd56);
							nxt_q       <= (fill_end < 6'd56) ? md5_pkg::NXT_NONE
							                                  : md5_pkg::NXT_LEN;
							fin_q       <= 1'b1;
						end
						if (blk_full || msg.last_byte) begin
							state_q <= md5_pkg::ST_ROUND;
							rnd_q   <= '0;
							a_q     <= chain_q[0];
							b_q     <= chain_q[1];
							c_q     <= chain_q[2];
							d_q     <= chain_q[3];
						end
					end
				end
				md5_pkg::ST_ROUND: begin
					a_q   <= d_q;
					b_q   <= b_new;
					c_q   <= b_q;
					d_q   <= c_q;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= md5_pkg::ST_FOLD;
					end
				end
				md5_pkg::ST_FOLD: begin
					chain_q <= fold_sum;
					a_q     <= fold_sum[0];
					b_q     <= fold_sum[1];
					c_q     <= fold_sum[2];
					d_q     <= fold_sum[3];
					rnd_q   <= '0;
					case (nxt_q)
						md5_pkg::NXT_MARK_LEN: begin
							blk_valid_q <= '0;
							blk_mark_q  <= 1'b1;
							blk_len_q   <= 1'b1;
							nxt_q       <= md5_pkg::NXT_NONE;
							state_q     <= md5_pkg::ST_ROUND;
						end
						md5_pkg::NXT_LEN: begin
							blk_valid_q <= '0;
							blk_mark_q  <= 1'b0;
							blk_len_q   <= 1'b1;
							nxt_q       <= md5_pkg::NXT_NONE;
							state_q     <= md5_pkg::ST_ROUND;
						end
						default: begin
							emit_idx_q <= '0;
							state_q    <= fin_q ? md5_pkg::ST_EMIT : md5_pkg::ST_IDLE;
						end
					endcase
				end
				md5_pkg::ST_EMIT: begin
					if (!out_vld_q || digest.ready) begin
						emit_idx_q <= emit_idx_q + 2'd1;
						if (emit_idx_q == 2'd3) begin
							// digest out; restart from the initial vector
							state_q   <= md5_pkg::ST_IDLE;
							fin_q     <= 1'b0;
							bit_cnt_q <= '0;
							chain_q   <= {md5_pkg::IV_D, md5_pkg::IV_C,
							              md5_pkg::IV_B, md5_pkg::IV_A};
						end
					end
				end
				default: begin
					state_q <= md5_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign digest.valid       = out_vld_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_idx_q;
	assign digest.last_word   = out_last_q;

endmodule

FILE: tb/tb.sv
// tb: self-checking bench for md5_message_digest against a local md5 digest
// depends on md5_pkg, md5_in_if, md5_out_if and md5_message_digest
`timescale 1ns / 1ps

module tb;

	localparam int STALL_LIMIT = 1000;  // cycles with no transfer on either channel
	localparam int DRAIN_WAIT  = 140;   // covers a two-block finish after the last word
	localparam int RANDOM_ITEMS = 15;
	localparam int RANDOM_MSGS  = 3;

	// additive round constants, rounds 0..63
	localparam logic [md5_pkg::WORD_W-1:0] SINE_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// left-rotate amounts, four per round group
	localparam int ROT_AMT [16] = '{
		7, 12, 17, 22,
		5,  9, 14, 20,
		4, 11, 16, 23,
		6, 10, 15, 21
	};

	// one digest word transfer as the block should present it
	typedef struct packed {
		logic [md5_pkg::WORD_W-1:0] word;
		logic [md5_pkg::IDX_W-1:0]  idx;
		logic                       last;
	} digest_beat_t;

	logic clk;
	logic arst_n;

	md5_in_if  msg_if ();
	md5_out_if dig_if ();

	md5_message_digest dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.digest (dig_if)
	);

	// running digest state, mirrors the engine between transfers
	logic [md5_pkg::WORD_W-1:0]  chain_q [4];
	logic [md5_pkg::COUNT_W-1:0] msg_bits;
	logic [md5_pkg::BYTE_W-1:0]  blk [64];
	logic [5:0]                  fill;

	digest_beat_t digest_due [$];

	int errors;
	int msg_items;     // transfers that carry a byte or end a message
	int idle_items;    // transfers with neither
	int msgs_sent;
	int words_seen;
	int burst_left;
	int quiet_cycles;

	logic [7:0] stall_pat;
	int         stall_age;

	// clock, 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// digest arithmetic
	// ------------------------------------------------------------------

	function automatic logic [md5_pkg::WORD_W-1:0] rotl(input logic [md5_pkg::WORD_W-1:0] v,
			input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic restart_digest();
		chain_q[0] = md5_pkg::IV_A;
		chain_q[1] = md5_pkg::IV_B;
		chain_q[2] = md5_pkg::IV_C;
		chain_q[3] = md5_pkg::IV_D;
		msg_bits = '0;
		fill = '0;
	endtask

	// 64 rounds over the current block, folded into the chaining words
	task automatic compress_block();
		logic [md5_pkg::WORD_W-1:0] m [16];
		logic [md5_pkg::WORD_W-1:0] a, b, c, d, f, t;
		int g;
		int grp;
		for (int i = 0; i < 16; i++)
			m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		a = chain_q[0];
		b = chain_q[1];
		c = chain_q[2];
		d = chain_q[3];
		for (int i = 0; i < 64; i++) begin
			grp = i / 16;
			case (grp)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			t = a + f + m[g] + SINE_K[i];
			t = b + rotl(t, ROT_AMT[grp * 4 + i % 4]);
			a = d;
			d = c;
			c = b;
			b = t;
		end
		chain_q[0] += a;
		chain_q[1] += b;
		chain_q[2] += c;
		chain_q[3] += d;
	endtask

	// absorb one accepted transfer; on a last flag pad, finish and queue four words
	task automatic absorb_item(input logic [md5_pkg::BYTE_W-1:0] b, input logic h,
			input logic l);
		logic [md5_pkg::COUNT_W-1:0] len;
		digest_beat_t beat;
		if (h) begin
			blk[fill] = b;
			msg_bits += 64'd8;
			fill = fill + 6'd1;
			if (fill == 6'd0)
				compress_block();
		end
		if (!l)
			return;
		len = msg_bits;
		blk[fill] = md5_pkg::PAD_MARK;
		fill = fill + 6'd1;
		// no room left for the length, so the padding spills into a second block
		if (fill == 6'd0 || fill > 6'd56) begin
			while (fill != 6'd0) begin
				blk[fill] = '0;
				fill = fill + 6'd1;
			end
			compress_block();
		end
		while (fill < 6'd56) begin
			blk[fill] = '0;
			fill = fill + 6'd1;
		end
		for (int i = 0; i < 8; i++)
			blk[56 + i] = len[8*i +: 8];
		compress_block();
		for (int i = 0; i < 4; i++) begin
			beat.word = chain_q[i];
			beat.idx  = md5_pkg::IDX_W'(i);
			beat.last = (i == 3);
			digest_due.push_back(beat);
		end
		restart_digest();
	endtask

	// ------------------------------------------------------------------
	// message channel driver
	// ------------------------------------------------------------------

	// one transfer; valid is held over a burst and may drop for a random gap between bursts
	task automatic push_item(input logic [md5_pkg::BYTE_W-1:0] b, input logic h,
			input logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				msg_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		msg_if.valid     <= 1'b1;
		msg_if.data_byte <= b;
		msg_if.has_byte  <= h;
		msg_if.last_byte <= l;
		@(posedge clk);
		while (!msg_if.ready)
			@(posedge clk);
		// transfer taken at this edge
		absorb_item(b, h, l);
		if (h || l)
			msg_items++;
		else
			idle_items++;
		if (l)
			msgs_sent++;
	endtask

	// a message of len random bytes with the odd idle item mixed in;
	// split_end closes it with a separate byte-less last transfer
	task automatic send_message(input int len, input bit split_end);
		for (int n = 0; n < len; n++) begin
			if ($urandom_range(0, 9) == 0)
				push_item(8'($urandom), 1'b0, 1'b0);
			push_item(8'($urandom), 1'b1, (n == len - 1) && !split_end);
		end
		if (len == 0 || split_end)
			push_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// digest channel: stall pattern and checker
	// ------------------------------------------------------------------

	// ready follows a rotating 8-bit pattern, reloaded each time stall_age wraps;
	// a third of the patterns never stall
	always @(posedge clk) begin
		if (stall_age == 0)
			stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hff : (8'($urandom) | 8'h01);
		else
			stall_pat <= {stall_pat[0], stall_pat[7:1]};
		stall_age = (stall_age + 1) % 48;
		dig_if.ready <= stall_pat[0];
	end

	always @(posedge clk) begin
		digest_beat_t want;
		if (arst_n && dig_if.valid && dig_if.ready) begin
			words_seen++;
			if (digest_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected digest transfer: word %h index %0d last %b",
					$time, dig_if.digest_word, dig_if.word_index, dig_if.last_word);
			end else begin
				want = digest_due.pop_front();
				if (dig_if.digest_word !== want.word || dig_if.word_index !== want.idx ||
						dig_if.last_word !== want.last) begin
					errors++;
					$display("%0t: digest mismatch: want %h/%0d/%b got %h/%0d/%b",
						$time, want.word, want.idx, want.last,
						dig_if.digest_word, dig_if.word_index, dig_if.last_word);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d digest words outstanding",
					$time, quiet_cycles, digest_due.size());
				$display("tb: errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// empty message, idle transfers that must change nothing, empty again
	task automatic test_empty_message();
		push_item(8'($urandom), 1'b0, 1'b1);
		push_item(8'hff, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// byte and last flag together: the byte is absorbed before the finish
	task automatic test_single_bytes();
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'hff, 1'b1, 1'b1);
		push_item(md5_pkg::PAD_MARK, 1'b1, 1'b1);
	endtask

	// finish on a byte-less last transfer, with an idle transfer mid-message
	task automatic test_split_finish();
		push_item(8'ha5, 1'b1, 1'b0);
		push_item(8'h3c, 1'b0, 1'b0);
		push_item(8'h5a, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
	endtask

	// pad mark and length just fit, just spill, and a last byte that fills the block
	task automatic test_pad_boundaries();
		send_message(55, 1'b0);
		send_message(56, 1'b1);
		send_message(64, 1'b0);
	endtask

	// a few short random messages with noise between them
	task automatic test_random_messages();
		int base_items;
		int base_msgs;
		int len;
		base_items = msg_items;
		base_msgs  = msgs_sent;
		while (msg_items - base_items < RANDOM_ITEMS || msgs_sent - base_msgs < RANDOM_MSGS)
				begin
			case ($urandom_range(0, 3))
				0:       len = $urandom_range(0, 3);
				default: len = $urandom_range(1, 12);
			endcase
			if ($urandom_range(0, 3) == 0)
				push_item(8'($urandom), 1'b0, 1'b0);
			send_message(len, (len == 0) || ($urandom_range(0, 1) == 1));
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		msg_if.valid     = 1'b0;
		msg_if.data_byte = '0;
		msg_if.has_byte  = 1'b0;
		msg_if.last_byte = 1'b0;
		dig_if.ready     = 1'b0;
		stall_pat        = 8'hff;
		stall_age        = 0;
		errors           = 0;
		msg_items        = 0;
		idle_items       = 0;
		msgs_sent        = 0;
		words_seen       = 0;
		burst_left       = 0;
		quiet_cycles     = 0;
		for (int i = 0; i < 64; i++)
			blk[i] = '0;
		restart_digest();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_message();
		test_single_bytes();
		test_split_finish();
		test_pad_boundaries();
		test_random_messages();

		msg_if.valid <= 1'b0;
		// drain, then give a stray word time to show up
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d message transfers and %0d idle ones, %0d messages",
			msg_items, idle_items, msgs_sent);
		$display("%0d digest words compared, %0d failures", words_seen, errors);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
